### rtl/jang_pkg.sv
// Shared types, widths and constants for the joint angle pipeline.
// No dependencies; imported by every module in rtl/.
package jang_pkg;

    localparam int ATAN_STAGES   = 16;
    localparam int TABLE_LEN     = 24;
    localparam int CORDIC_STAGES = (ATAN_STAGES < TABLE_LEN) ? ATAN_STAGES : TABLE_LEN;

    localparam int IW  = 16;   // input coordinate width
    localparam int DW  = 17;   // joint difference width
    localparam int PW  = 34;   // product width
    localparam int SW  = 35;   // cross / dot width
    localparam int NW  = 42;   // normalized width
    localparam int CW  = 46;   // CORDIC x/y width
    localparam int ZW  = 30;   // angle accumulator width, 2^-20 degree
    localparam int SHW = 6;    // normalize shift width
    localparam int OW  = 16;   // output angle width

    localparam int NORM_BIT  = 40;
    localparam int DEG90_Z   = 94371840;
    localparam int ROUND_SH  = 13;
    localparam int OUT_LIMIT = 23040;

    localparam int ATAN_TAB [TABLE_LEN] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458,
        229, 115, 57, 29, 14, 7
    };

    typedef logic signed [ZW-1:0] zval_t;

    typedef struct packed {
        logic signed [IW-1:0] inner_y;
        logic signed [IW-1:0] inner_x;
        logic signed [IW-1:0] outer_y;
        logic signed [IW-1:0] outer_x;
        logic signed [IW-1:0] pivot_y;
        logic signed [IW-1:0] pivot_x;
    } joints_t;

    typedef struct packed {
        logic signed [SW-1:0] crs;
        logic signed [SW-1:0] dot;
    } vec_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        zval_t                z;
        logic                 zero;
    } cordic_t;

endpackage

### rtl/jang_prod.sv
// Joint differences, products and cross/dot sums: three register stages.
// Depends on jang_pkg.
module jang_prod
    import jang_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  joints_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output vec_t    out_data
);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic signed [DW-1:0] ox_reg, oy_reg, vx_reg, vy_reg;
    logic signed [DW-1:0] ox_next, oy_next, vx_next, vy_next;

    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [PW-1:0] pa_next, pb_next, pc_next, pd_next;
    logic signed [DW-1:0] vx2_reg, vy2_reg;
    logic                 oz2_reg, oz2_next;

    vec_t out_reg, out_next;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        ox_next = DW'(in_data.outer_x) - DW'(in_data.pivot_x);
        oy_next = DW'(in_data.outer_y) - DW'(in_data.pivot_y);
        vx_next = DW'(in_data.inner_x) - DW'(in_data.pivot_x);
        vy_next = DW'(in_data.inner_y) - DW'(in_data.pivot_y);
    end

    always_comb begin
        pa_next  = ox_reg * vy_reg;
        pb_next  = oy_reg * vx_reg;
        pc_next  = ox_reg * vx_reg;
        pd_next  = oy_reg * vy_reg;
        oz2_next = (ox_reg == '0) && (oy_reg == '0);
    end

    always_comb begin
        if (oz2_reg) begin
            out_next.crs = SW'(vy2_reg);
            out_next.dot = SW'(vx2_reg);
        end else begin
            out_next.crs = SW'(pa_reg) - SW'(pb_reg);
            out_next.dot = SW'(pc_reg) + SW'(pd_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            vx_reg <= vx_next;
            vy_reg <= vy_next;
        end
        if (en2) begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            pc_reg  <= pc_next;
            pd_reg  <= pd_next;
            vx2_reg <= vx_reg;
            vy2_reg <= vy_reg;
            oz2_reg <= oz2_next;
        end
        if (en3) out_reg <= out_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule

### rtl/jang_norm.sv
// Leading-one search, normalizing shift and half-plane pre-rotation.
// Depends on jang_pkg.
module jang_norm
    import jang_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  vec_t    in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cordic_t out_data
);

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic [SW-1:0]        ax, ay, mx;
    logic [SHW-1:0]       msb;
    logic signed [SW-1:0] x1_reg, y1_reg;
    logic [SHW-1:0]       sh1_reg, sh1_next;
    logic                 zero1_reg, zero1_next;

    logic signed [NW-1:0] x2_reg, y2_reg, x2_next, y2_next;
    logic                 zero2_reg;

    logic signed [CW-1:0] xe, ye;
    cordic_t              out_reg, out_next;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        ax  = in_data.dot[SW-1] ? SW'(-in_data.dot) : SW'(in_data.dot);
        ay  = in_data.crs[SW-1] ? SW'(-in_data.crs) : SW'(in_data.crs);
        mx  = (ax > ay) ? ax : ay;
        msb = '0;
        for (int b = 0; b < SW; b++) begin
            if (mx[b]) msb = SHW'(b);
        end
        zero1_next = (mx == '0);
        sh1_next   = zero1_next ? '0 : SHW'(NORM_BIT) - msb;
    end

    always_comb begin
        x2_next = NW'(x1_reg) <<< sh1_reg;
        y2_next = NW'(y1_reg) <<< sh1_reg;
    end

    // bring the vector into the right half plane
    always_comb begin
        xe            = CW'(x2_reg);
        ye            = CW'(y2_reg);
        out_next.zero = zero2_reg;
        if (xe[CW-1]) begin
            if (!ye[CW-1]) begin
                out_next.x = ye;
                out_next.y = -xe;
                out_next.z = ZW'(DEG90_Z);
            end else begin
                out_next.x = -ye;
                out_next.y = xe;
                out_next.z = -ZW'(DEG90_Z);
            end
        end else begin
            out_next.x = xe;
            out_next.y = ye;
            out_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            x1_reg    <= in_data.dot;
            y1_reg    <= in_data.crs;
            sh1_reg   <= sh1_next;
            zero1_reg <= zero1_next;
        end
        if (en2) begin
            x2_reg    <= x2_next;
            y2_reg    <= y2_next;
            zero2_reg <= zero1_reg;
        end
        if (en3) out_reg <= out_next;
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

    a_right_half: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> !out_data.x[CW-1])
        else $error("pre-rotated x is negative");

    a_zero_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_data.zero) |-> (out_data.x == '0 && out_data.y == '0))
        else $error("zero flag set on nonzero vector");

endmodule

### rtl/jang_cordic.sv
// Vectoring CORDIC, one iteration per register stage, then rounding and clamp.
// Depends on jang_pkg.
module jang_cordic
    import jang_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cordic_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [OW-1:0] out_data
);

    localparam int RW = ZW + 1;
    localparam int QW = RW - ROUND_SH;

    cordic_t st_reg [CORDIC_STAGES];
    logic    v_reg  [CORDIC_STAGES];
    logic    en     [CORDIC_STAGES+1];

    logic                 out_v_reg;
    logic signed [OW-1:0] out_reg, out_next;
    logic signed [RW-1:0] zsum;
    logic signed [QW-1:0] zq;
    cordic_t              last;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        cordic_t              src, nxt;
        logic                 src_v;
        logic signed [CW-1:0] sx, sy, xs, ys;

        if (k == 0) begin : g_first
            assign src   = in_data;
            assign src_v = in_valid;
        end else begin : g_rest
            assign src   = st_reg[k-1];
            assign src_v = v_reg[k-1];
        end

        assign en[k] = !v_reg[k] || en[k+1];

        always_comb begin
            sx       = src.x;
            sy       = src.y;
            xs       = sx >>> k;
            ys       = sy >>> k;
            nxt.zero = src.zero;
            if (!sy[CW-1]) begin
                nxt.x = sx + ys;
                nxt.y = sy - xs;
                nxt.z = src.z + ZW'(ATAN_TAB[k]);
            end else begin
                nxt.x = sx - ys;
                nxt.y = sy + xs;
                nxt.z = src.z - ZW'(ATAN_TAB[k]);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) st_reg[k] <= nxt;
        end
    end

    assign en[CORDIC_STAGES] = !out_v_reg || out_ready;
    assign in_ready          = en[0];
    assign last              = st_reg[CORDIC_STAGES-1];

    // round to nearest, tie upward, then clamp to +-180 degrees; a zero vector gives 0
    always_comb begin
        zsum = RW'(last.z) + RW'(1 << (ROUND_SH - 1));
        zq   = QW'(zsum >>> ROUND_SH);
        if (last.zero) begin
            out_next = '0;
        end else if (zq > QW'(OUT_LIMIT)) begin
            out_next = OW'(OUT_LIMIT);
        end else if (zq < -QW'(OUT_LIMIT)) begin
            out_next = -OW'(OUT_LIMIT);
        end else begin
            out_next = OW'(zq);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en[CORDIC_STAGES]) begin
            out_v_reg <= v_reg[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[CORDIC_STAGES]) out_reg <= out_next;
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_data <= OW'(OUT_LIMIT) && out_data >= -OW'(OUT_LIMIT)))
        else $error("angle outside +-180 degrees");

endmodule

### rtl/joint_angle_2d_top.sv
// Top level of the joint angle block: stream ports and the three pipeline parts.
// Depends on jang_pkg, jang_prod, jang_norm and jang_cordic.
//
// Takes one joint triple per transfer and returns the signed angle at the pivot,
// from the outer limb vector to the inner one, in 1/128 degree, clamped to
// +-180 degrees. A zero outer vector gives the angle of the inner vector alone;
// two zero vectors give 0. The pipeline accepts a transfer every cycle while
// m_tready is high and delivers one result per transfer in order. It holds
// three stages of differences, products and sums, three of normalizing, one
// per CORDIC iteration and the output register. Each stage advances when it
// is empty or the stage after it moves, so m_tready low fills empty stages
// before s_tready drops.
module joint_angle_2d_top
    import jang_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pivot_x, pivot_y, outer_x, outer_y, inner_x, inner_y (16 bits each)
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // joint_angle (16 bits, signed)
    output logic [15:0] m_tdata
);

    joints_t              joints;
    vec_t                 vec;
    cordic_t              cvec;
    logic                 vec_valid, vec_ready, cv_valid, cv_ready;
    logic signed [OW-1:0] angle;

    assign joints = joints_t'(s_tdata);

    jang_prod u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (joints),
        .out_valid (vec_valid),
        .out_ready (vec_ready),
        .out_data  (vec)
    );

    jang_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vec_valid),
        .in_ready  (vec_ready),
        .in_data   (vec),
        .out_valid (cv_valid),
        .out_ready (cv_ready),
        .out_data  (cvec)
    );

    jang_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cv_valid),
        .in_ready  (cv_ready),
        .in_data   (cvec),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (angle)
    );

    assign m_tdata = angle;

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage is empty");

endmodule
